FILE: hdl/tmps_pkg.sv
// tmps_pkg: constants, types and state codes for the trimmed-mean pH sensor core
// used by the interfaces, the insertion cells, the divider and the top level
`default_nettype none

package tmps_pkg;

  // window geometry
  localparam int WINDOW   = 10;
  localparam int TRIM     = 2;
  localparam int ADC_BITS = 12;

  // kept span of the sorted window; a trim that eats the window keeps the middle entry
  localparam int FIRST = (2 * TRIM >= WINDOW) ? (WINDOW / 2) : TRIM;
  localparam int KEEP  = (2 * TRIM >= WINDOW) ? 1 : (WINDOW - 2 * TRIM);

  // fixed field widths
  localparam int SAMPLE_W  = 12;
  localparam int CFG_W     = 24;
  localparam int PH_W      = 24;
  localparam int MEAN_W    = 12;
  localparam int CFG_IDX_W = 1;

  // q24 slope times counts down to q16 pH is a divide by 256
  localparam int DEN_SH = 8;

  // derived datapath widths
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SUM_W  = ADC_BITS + $clog2(KEEP);
  localparam int PROD_W = CFG_W + SUM_W + 1;
  localparam int NUM_W  = PROD_W + 1;

  // |slope * sum| plus the rounding and floor terms stays below 2^MAG_W
  localparam int MAG_W   = CFG_W + SUM_W - 1;
  localparam int PH_X_W  = MAG_W - DEN_SH;
  localparam int QUO_W   = PH_X_W + 1;
  localparam int KEEP_LG = $clog2(KEEP);

  // divisor for the pH term is kept count times 256, rounding adds half of it
  localparam logic [NUM_W-1:0] DEN_PH   = NUM_W'(KEEP << DEN_SH);
  localparam logic [NUM_W-1:0] DEN_HALF = NUM_W'(KEEP << (DEN_SH - 1));

  // reciprocals of the kept count, exact for operands below 2^PH_X_W and 2^SUM_W
  localparam int RCP_SH_PH = PH_X_W + KEEP_LG;
  localparam int RCP_SH_MN = SUM_W + KEEP_LG;
  localparam logic [PH_X_W:0] RCP_PH =
    (PH_X_W + 1)'(((longint'(1) << RCP_SH_PH) + KEEP - 1) / KEEP);
  localparam logic [SUM_W:0]  RCP_MN =
    (SUM_W + 1)'(((longint'(1) << RCP_SH_MN) + KEEP - 1) / KEEP);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

  // register reset values
  localparam logic signed [CFG_W-1:0] SLOPE_RST  = -24'sd59894;
  localparam logic signed [CFG_W-1:0] OFFSET_RST = 24'sd1279967;

  // output saturation limits
  localparam logic signed [PH_W-1:0] PH_MAX = 24'sh7FFFFF;
  localparam logic signed [PH_W-1:0] PH_MIN = 24'sh800000;

  // link between neighboring insertion cells
  typedef struct packed {
    logic                occ;
    logic                gt;
    logic [ADC_BITS-1:0] val;
  } cell_link_t;

  // control sequence of the top level
  typedef enum logic [2:0] {
    ST_FILL,
    ST_SUM,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } tmps_state_t;

endpackage

`default_nettype wire

FILE: hdl/tmps_if.sv
// tmps_if: valid/ready channel interfaces for samples and results
// depends on tmps_pkg for the field widths
`default_nettype none

interface tmps_in_if;
  logic                              valid;
  logic                              ready;
  logic [tmps_pkg::SAMPLE_W-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmps_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tmps_pkg::PH_W-1:0]  ph_q16;
  logic [tmps_pkg::MEAN_W-1:0]       mean_counts;

  modport source (output valid, output ph_q16, output mean_counts, input ready);
  modport sink   (input valid, input ph_q16, input mean_counts, output ready);
endinterface

`default_nettype wire

FILE: hdl/trimmed_mean_ph_sensor_core.sv
// trimmed_mean_ph_sensor_core: top level of the trimmed-mean pH front end
// depends on tmps_pkg, tmps_if, tmps_cell and tmps_div
//
// Samples arrive on in_ch (valid/ready); one transfer each cycle while the
// window fills. Each sample is placed in order by a chain of WINDOW cells in
// the cycle it is taken. The transfer that completes the window starts the
// result: the kept middle entries are summed one per cycle, the
// sum is multiplied by slope_q24, then the divide unit forms the
// rounded pH term and the mean by reciprocal multiplication.
// in_ch is held not ready from the transfer that completes a window until the
// result moves into the output register.
// The result sits in an output register; the next window fills while it
// waits. If out_ch is still stalled when the following result is ready, the
// core holds that result and takes no sample until the register frees.
// cfg_we/cfg_idx/cfg_wdata write slope_q24 (index 0) and offset_q16
// (index 1) with no wait. Synchronous reset empties the chain, restores the
// calibration defaults and drops any pending result.
`default_nettype none

module trimmed_mean_ph_sensor_core (
  input  wire                                clk,
  input  wire                                rst_n,
  tmps_in_if.sink                            in_ch,
  tmps_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [tmps_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire [tmps_pkg::CFG_W-1:0]          cfg_wdata
);

  tmps_pkg::tmps_state_t state_r, state_nxt;

  logic signed [tmps_pkg::CFG_W-1:0]  slope_r, offset_r;
  logic [tmps_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic [tmps_pkg::IDX_W-1:0]         cnt_r, cnt_nxt;
  logic signed [tmps_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [tmps_pkg::PH_W-1:0]   ph_r, ph_nxt;
  logic [tmps_pkg::MEAN_W-1:0]        mean_r, mean_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [tmps_pkg::PH_W-1:0]   out_ph_r, out_ph_nxt;
  logic [tmps_pkg::MEAN_W-1:0]        out_mean_r, out_mean_nxt;

  tmps_pkg::cell_link_t               lnk [tmps_pkg::WINDOW];
  tmps_pkg::cell_link_t               head;
  logic [tmps_pkg::WINDOW-1:0]        occ_vec;
  logic [tmps_pkg::ADC_BITS-1:0]      smp;
  logic                               ins;
  logic                               chain_clr;
  logic [tmps_pkg::IDX_W-1:0]         rd_idx;
  logic                               sum_last;
  logic                               out_free;

  logic                               div_start;
  logic                               div_done;
  logic signed [tmps_pkg::QUO_W-1:0]  div_quo;
  logic [tmps_pkg::MEAN_W-1:0]        div_mean;
  logic signed [tmps_pkg::QUO_W:0]    ph_sum;
  logic signed [tmps_pkg::PROD_W-1:0] prod_full;
  logic                               sorted_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= tmps_pkg::SLOPE_RST;
      offset_r <= tmps_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tmps_pkg::CFG_SLOPE:  slope_r  <= cfg_wdata;
        tmps_pkg::CFG_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // insertion chain
  assign smp         = in_ch.sample[tmps_pkg::ADC_BITS-1:0];
  assign in_ch.ready = (state_r == tmps_pkg::ST_FILL);
  assign ins         = in_ch.valid && in_ch.ready;
  assign head.occ    = 1'b1;
  assign head.gt     = 1'b0;
  assign head.val    = '0;

  for (genvar i = 0; i < tmps_pkg::WINDOW; i++) begin : g_chain
    tmps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ins    (ins),
      .clr    (chain_clr),
      .sample (smp),
      .left   ((i == 0) ? head : lnk[(i == 0) ? 0 : i - 1]),
      .link_o (lnk[i])
    );
    assign occ_vec[i] = lnk[i].occ;
  end

  // kept-span read and product
  assign rd_idx    = tmps_pkg::IDX_W'(tmps_pkg::FIRST) + cnt_r;
  assign sum_last  = (cnt_r == tmps_pkg::IDX_W'(tmps_pkg::KEEP - 1));
  assign prod_full = slope_r * $signed({1'b0, sum_r});
  assign out_free  = !out_valid_r || out_ch.ready;

  // divide unit: rounded pH term and mean together
  assign div_start = (state_r == tmps_pkg::ST_DIV_GO);

  tmps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .prod  (prod_r),
    .sum   (sum_r),
    .done  (div_done),
    .quo   (div_quo),
    .mean  (div_mean)
  );

  assign ph_sum = (tmps_pkg::QUO_W + 1)'(offset_r) + (tmps_pkg::QUO_W + 1)'(div_quo);

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    ph_nxt        = ph_r;
    mean_nxt      = mean_r;
    chain_clr     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_ph_nxt    = out_ph_r;
    out_mean_nxt  = out_mean_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tmps_pkg::ST_FILL: begin
        cnt_nxt = '0;
        sum_nxt = '0;
        if (ins && occ_vec[tmps_pkg::WINDOW-2]) begin
          state_nxt = tmps_pkg::ST_SUM;
        end
      end
      tmps_pkg::ST_SUM: begin
        sum_nxt = sum_r + tmps_pkg::SUM_W'(lnk[rd_idx].val);
        cnt_nxt = cnt_r + 1'b1;
        if (sum_last) begin
          chain_clr = 1'b1;
          state_nxt = tmps_pkg::ST_MUL;
        end
      end
      tmps_pkg::ST_MUL: begin
        prod_nxt  = prod_full;
        state_nxt = tmps_pkg::ST_DIV_GO;
      end
      tmps_pkg::ST_DIV_GO: begin
        state_nxt = tmps_pkg::ST_DIV_WAIT;
      end
      tmps_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (ph_sum > (tmps_pkg::QUO_W + 1)'(tmps_pkg::PH_MAX)) begin
            ph_nxt = tmps_pkg::PH_MAX;
          end else if (ph_sum < (tmps_pkg::QUO_W + 1)'(tmps_pkg::PH_MIN)) begin
            ph_nxt = tmps_pkg::PH_MIN;
          end else begin
            ph_nxt = ph_sum[tmps_pkg::PH_W-1:0];
          end
          mean_nxt  = div_mean;
          state_nxt = tmps_pkg::ST_OUT;
        end
      end
      tmps_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ph_nxt    = ph_r;
          out_mean_nxt  = mean_r;
          state_nxt     = tmps_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = tmps_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmps_pkg::ST_FILL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    ph_r       <= ph_nxt;
    mean_r     <= mean_nxt;
    out_ph_r   <= out_ph_nxt;
    out_mean_r <= out_mean_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ph_q16      = out_ph_r;
  assign out_ch.mean_counts = out_mean_r;

  // occupied cells must hold nondecreasing values
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < tmps_pkg::WINDOW; i++) begin
      if (lnk[i].occ && (lnk[i-1].val > lnk[i].val)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // chain fills from the low end without holes
  a_occ_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_vec & tmps_pkg::WINDOW'(occ_vec + 1'b1)) == '0)
    else $error("insertion chain has a hole");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
    else $error("insertion chain out of order");

  // chain is empty once the kept span has been summed
  a_clear_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmps_pkg::ST_SUM && sum_last) |=> (occ_vec == '0))
    else $error("chain not cleared after sum");

  // divide unit finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == tmps_pkg::ST_DIV_WAIT))
    else $error("divider done outside the wait state");

  // a full window always moves into summing
  a_full_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (ins && occ_vec[tmps_pkg::WINDOW-2]) |=> (state_r == tmps_pkg::ST_SUM))
    else $error("full window did not start summing");

endmodule

`default_nettype wire

FILE: hdl/tmps_cell.sv
// tmps_cell: one slot of the sorted insertion chain
// depends on tmps_pkg for cell_link_t and ADC_BITS
`default_nettype none

module tmps_cell (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             ins,
  input  wire                             clr,
  input  wire [tmps_pkg::ADC_BITS-1:0]    sample,
  input  wire tmps_pkg::cell_link_t       left,
  output tmps_pkg::cell_link_t            link_o
);

  logic                          occ_r, occ_nxt;
  logic [tmps_pkg::ADC_BITS-1:0] val_r, val_nxt;
  logic                          gt;
  logic                          take;

  // this slot holds a larger value, or is the first empty slot
  assign gt   = occ_r && (val_r > sample);
  assign take = gt || (!occ_r && left.occ);

  // on insert the slot takes its left neighbor if that one moves too, else the sample
  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (clr) begin
      occ_nxt = 1'b0;
    end else if (ins && take) begin
      occ_nxt = 1'b1;
      val_nxt = left.gt ? left.val : sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link_o.occ = occ_r;
  assign link_o.gt  = gt;
  assign link_o.val = val_r;

endmodule

`default_nettype wire

FILE: hdl/tmps_div.sv
// tmps_div: floor division of the rounded pH term and of the mean by the kept count,
// by reciprocal multiplication
// depends on tmps_pkg for the widths and the reciprocal constants
`default_nettype none

module tmps_div (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire signed [tmps_pkg::PROD_W-1:0]    prod,
  input  wire [tmps_pkg::SUM_W-1:0]            sum,
  output logic                                 done,
  output logic signed [tmps_pkg::QUO_W-1:0]    quo,
  output logic [tmps_pkg::MEAN_W-1:0]          mean
);

  logic [2:0]                          stg_r, stg_nxt;
  logic signed [tmps_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic                                neg_r, neg_nxt;
  logic [tmps_pkg::PH_X_W-1:0]         x_r, x_nxt;
  logic [tmps_pkg::PH_X_W-1:0]         q_r, q_nxt;
  logic [tmps_pkg::MEAN_W-1:0]         mean_r, mean_nxt;
  logic [tmps_pkg::NUM_W-1:0]          mag;
  logic [2*tmps_pkg::PH_X_W:0]         ph_prod;
  logic [2*tmps_pkg::SUM_W:0]          mn_prod;

  // floor for negatives: magnitude -n + d - 1, quotient negated at the end
  assign mag     = num_r[tmps_pkg::NUM_W-1] ? (~num_r + tmps_pkg::DEN_PH) : num_r;
  assign ph_prod = x_r * tmps_pkg::RCP_PH;
  assign mn_prod = sum * tmps_pkg::RCP_MN;

  // stage 0 rounds and forms the mean, stage 1 drops the 256, stage 2 divides by the count
  always_comb begin
    stg_nxt  = {stg_r[1:0], start};
    num_nxt  = num_r;
    neg_nxt  = neg_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    mean_nxt = mean_r;
    if (start) begin
      num_nxt  = tmps_pkg::NUM_W'(prod) + $signed(tmps_pkg::DEN_HALF);
      mean_nxt = tmps_pkg::MEAN_W'(mn_prod >> tmps_pkg::RCP_SH_MN);
    end
    if (stg_r[0]) begin
      neg_nxt = num_r[tmps_pkg::NUM_W-1];
      x_nxt   = mag[tmps_pkg::MAG_W-1:tmps_pkg::DEN_SH];
    end
    if (stg_r[1]) begin
      q_nxt = tmps_pkg::PH_X_W'(ph_prod >> tmps_pkg::RCP_SH_PH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= stg_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    q_r    <= q_nxt;
    mean_r <= mean_nxt;
  end

  assign done = stg_r[2];
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign mean = mean_r;

endmodule

`default_nettype wire

FILE: dv/tmps_result_check.sv
`timescale 1ns / 100ps
// tmps_result_check: watches the sample, result and calibration ports of the core,
// keeps its own sorted window and calibration copy and compares every result
// depends on tmps_pkg and the channel interfaces of tmps_if
module tmps_result_check (
  input  wire                            clk,
  input  wire                            rst_n,
  tmps_in_if                             in_ch,
  tmps_out_if                            out_ch,
  input  wire                            cfg_we,
  input  wire [tmps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire [tmps_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             mismatches,
  output int                             awaited,
  output int                             results_seen
);
  import tmps_pkg::*;

  typedef struct {
    logic signed [PH_W-1:0] ph;
    logic [MEAN_W-1:0]      mean;
  } ph_result_t;

  // predicted results not yet seen on the output
  ph_result_t ph_due[$];

  // sorted window and calibration copy
  logic [ADC_BITS-1:0]     window_vals [WINDOW];
  int                      fill = 0;
  logic signed [CFG_W-1:0] slope = SLOPE_RST;
  logic signed [CFG_W-1:0] offset = OFFSET_RST;

  int bad_count = 0;
  int results_total = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $realtime, what);
    bad_count++;
  endtask

  // offset + slope * mean, rounded to the nearest q16 step, saturated
  function automatic ph_result_t trimmed_ph(input longint kept_sum);
    longint den, num, quo, ph_full;
    ph_result_t r;
    den = longint'(KEEP) * 256;
    num = longint'(slope) * kept_sum + den / 2;
    quo = (num >= 0) ? num / den : -((-num + den - 1) / den);
    ph_full = longint'(offset) + quo;
    if (ph_full > longint'(PH_MAX)) ph_full = longint'(PH_MAX);
    if (ph_full < longint'(PH_MIN)) ph_full = longint'(PH_MIN);
    r.ph = ph_full[PH_W-1:0];
    r.mean = MEAN_W'(kept_sum / KEEP);
    return r;
  endfunction

  // insert behind every entry not greater, close the window when full
  task automatic take_sample(input logic [ADC_BITS-1:0] s);
    int pos;
    longint kept;
    pos = fill;
    while (pos > 0 && window_vals[pos-1] > s) begin
      window_vals[pos] = window_vals[pos-1];
      pos--;
    end
    window_vals[pos] = s;
    fill++;
    if (fill == WINDOW) begin
      kept = 0;
      for (int i = 0; i < KEEP; i++) kept += window_vals[FIRST + i];
      ph_due.push_back(trimmed_ph(kept));
      fill = 0;
    end
  endtask

  // compare one result transfer with the oldest prediction
  task automatic take_result();
    ph_result_t want;
    results_total++;
    if (ph_due.size() == 0) begin
      report_mismatch($sformatf("result %0d (ph_q16 %0d, mean_counts %0d) with none due",
                                results_total, out_ch.ph_q16, out_ch.mean_counts));
    end else begin
      want = ph_due.pop_front();
      if (out_ch.ph_q16 !== want.ph)
        report_mismatch($sformatf("result %0d: ph_q16 %0d, predicted %0d",
                                  results_total, out_ch.ph_q16, want.ph));
      if (out_ch.mean_counts !== want.mean)
        report_mismatch($sformatf("result %0d: mean_counts %0d, predicted %0d",
                                  results_total, out_ch.mean_counts, want.mean));
    end
  endtask

  // sample all ports at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      ph_due.delete();
      fill = 0;
      slope = SLOPE_RST;
      offset = OFFSET_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SLOPE) slope = cfg_wdata;
        else if (cfg_idx == CFG_OFFSET) offset = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) take_result();
      if (in_ch.valid && in_ch.ready) take_sample(in_ch.sample[ADC_BITS-1:0]);
    end
    mismatches <= bad_count;
    awaited <= ph_due.size();
    results_seen <= results_total;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: drives samples, calibration writes and result back-pressure into
// trimmed_mean_ph_sensor_core and gives the verdict from tmps_result_check
// depends on tmps_pkg, tmps_if, the core and tmps_result_check
module testbench;
  import tmps_pkg::*;

  localparam int RUN_ITEMS   = 900;
  localparam int SETTLE      = 150;
  localparam int DRAIN       = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_OPENING   = 24;
  localparam int N_CORNERS   = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_SLOPE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int mismatches, awaited, results_seen;
  int cycles = 0;
  int samples_sent = 0;
  int random_sent = 0;
  int settings_used = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  // opening windows: extremes out of order, then all-equal ties, then a partial window
  logic [SAMPLE_W-1:0] opening [N_OPENING] = '{
    12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h800, 12'h001, 12'hFFE, 12'h003, 12'hFFF, 12'h000,
    12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA,
    12'h555, 12'hFFF, 12'h000, 12'h7FF
  };

  // calibration corners: saturate high, saturate low, zero, mixed signs
  logic [CFG_W-1:0] corner_slope [N_CORNERS] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF
  };
  logic [CFG_W-1:0] corner_offset [N_CORNERS] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000, 24'h7FFFFF, 24'h000000
  };

  tmps_in_if  in_ch ();
  tmps_out_if out_ch ();

  trimmed_mean_ph_sensor_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tmps_result_check result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, awaited);
      $display("** trimmed_mean_ph_sensor_core: FAILED **");
      $finish;
    end
  end

  // one sample transfer, preceded by a random gap unless running steady
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // drain all results, let the core go idle, then load both registers
  task automatic recalibrate(input logic [CFG_W-1:0] new_slope,
                             input logic [CFG_W-1:0] new_offset);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SLOPE;
    cfg_wdata <= new_slope;
    @(posedge clk);
    cfg_idx <= CFG_OFFSET;
    cfg_wdata <= new_offset;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly full range, some clusters with ties, some rails
  function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [SAMPLE_W-1:0] center);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return center + SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // result side back-pressure
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int phase;
    int n;
    logic [SAMPLE_W-1:0] center;
    logic [CFG_W-1:0] s_val, o_val;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening windows run on the reset calibration
    foreach (opening[i]) send_sample(opening[i]);

    // random phases, each under its own calibration and idle pattern
    phase = 0;
    while (random_sent < RUN_ITEMS) begin
      if (phase < N_CORNERS) begin
        s_val = corner_slope[phase];
        o_val = corner_offset[phase];
      end else begin
        s_val = $urandom_range(0, 1) ? CFG_W'($urandom)
                                     : SLOPE_RST + CFG_W'($urandom_range(0, 65535)) - 24'd32768;
        o_val = $urandom_range(0, 1) ? CFG_W'($urandom)
                                     : OFFSET_RST + CFG_W'($urandom_range(0, 1048575)) - 24'd524288;
      end
      recalibrate(s_val, o_val);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      center = SAMPLE_W'($urandom);
      n = $urandom_range(10, 80);
      repeat (n) send_sample(draw_sample(center));
      random_sent += n;
      phase++;
    end

    // drain and watch for stray results
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d samples (%0d random) and %0d results under %0d calibration loads",
             samples_sent, random_sent, results_seen, settings_used);
    $display("idle gaps of 0 to 17 cycles on both sides, steady stretches, drains before loads");
    if (mismatches == 0 && awaited == 0) begin
      $display("** trimmed_mean_ph_sensor_core: PASSED **");
    end else begin
      $display("** trimmed_mean_ph_sensor_core: FAILED **");
    end
    $finish;
  end

endmodule
